// File: rtl/core/multichannel_sensor_average_filter_core_assert.svh
// assertion macros used by the filter back end
`ifndef MULTICHANNEL_SENSOR_AVERAGE_FILTER_CORE_ASSERT_SVH
`define MULTICHANNEL_SENSOR_AVERAGE_FILTER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/mcsaf_pkg.sv
// types and constants of the multichannel sensor average filter
package mcsaf_pkg;

  localparam int NUM_OFFSETS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  localparam logic signed [15:0] ERR_LIMIT = -16'sd9998;
  localparam logic signed [20:0] SCALE     = 21'sd10;
  localparam logic signed [31:0] SAT_HI    = 32'sd500000;
  localparam logic signed [31:0] SAT_LO    = -32'sd500000;

  typedef enum logic [1:0] {
    REG_ENABLE  = 2'd0,
    REG_OFFSET0 = 2'd1,
    REG_OFFSET1 = 2'd2,
    REG_OFFSET2 = 2'd3
  } cfg_reg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [1:0]         ch;
    logic               err;
    logic signed [20:0] addend;
  } item_t;

  // result word
  typedef struct packed {
    logic [1:0]         ch;
    logic signed [19:0] value;
    logic               err;
  } result_t;

endpackage

// File: rtl/core/mcsaf_fifo.sv
// small register queue with push/pop handshake
module mcsaf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/mcsaf_front.sv
// front end: configuration registers, channel filtering, fault detection and scaling
module mcsaf_front
  import mcsaf_pkg::*;
#(
  parameter int CHANNELS = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [17:0]         cfg_data,
  input  logic [1:0]          channel,
  input  logic signed [15:0]  sample,
  input  logic                accept,
  output logic                keep,
  output item_t               item
);

  logic [2:0]         enable_mask;
  logic signed [17:0] offset [NUM_OFFSETS];
  logic               chan_en;
  logic signed [17:0] chan_off;
  logic signed [20:0] scaled;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask <= 3'b111;
      for (int i = 0; i < NUM_OFFSETS; i++) begin
        offset[i] <= '0;
      end
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_ENABLE:  enable_mask <= cfg_data[2:0];
        REG_OFFSET0: offset[0]   <= cfg_data;
        REG_OFFSET1: offset[1]   <= cfg_data;
        REG_OFFSET2: offset[2]   <= cfg_data;
        default:     enable_mask <= enable_mask;
      endcase
    end
  end

  // channels past the offset registers are always enabled with no offset
  always_comb begin
    case (channel)
      2'd0:    begin chan_en = enable_mask[0]; chan_off = offset[0]; end
      2'd1:    begin chan_en = enable_mask[1]; chan_off = offset[1]; end
      2'd2:    begin chan_en = enable_mask[2]; chan_off = offset[2]; end
      default: begin chan_en = 1'b1;           chan_off = '0;        end
    endcase
  end

  assign scaled = {{5{sample[15]}}, sample} * SCALE;

  assign keep        = accept && chan_en && (int'(channel) < CHANNELS);
  assign item.ch     = channel;
  assign item.err    = (sample <= ERR_LIMIT);
  assign item.addend = scaled + {{3{chan_off[17]}}, chan_off};

endmodule

// File: rtl/core/mcsaf_div.sv
// iterative signed-by-unsigned divider, one quotient bit per cycle, truncates toward zero
module mcsaf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [7:0]         divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic        busy;
  logic        neg;
  logic [4:0]  step;
  logic [31:0] q;
  logic [7:0]  rem;
  logic [7:0]  dvs;
  logic [8:0]  rem_sh;
  logic        ge;
  logic [8:0]  rem_sub;

  assign rem_sh  = {rem, q[31]};
  assign ge      = (rem_sh >= {1'b0, dvs});
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[31];
      q   <= dividend[31] ? 32'(-dividend) : 32'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      q   <= {q[30:0], ge};
      rem <= ge ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);

endmodule

// File: rtl/core/mcsaf_back.sv
// back end: per-channel running state, average computation and result staging
`include "multichannel_sensor_average_filter_core_assert.svh"

module mcsaf_back
  import mcsaf_pkg::*;
#(
  parameter int CHANNELS  = 3,
  parameter int MAX_COUNT = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    q_empty,
  input  item_t   q_item,
  output logic    q_pop,
  input  logic    res_full,
  output logic    res_push,
  output result_t res
);

  localparam int         CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [7:0] CNT_MAX = 8'(MAX_COUNT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  logic [31:0]        acc  [CHANNELS];
  logic [7:0]         cnt  [CHANNELS];
  logic signed [19:0] last [CHANNELS];

  item_t              cur;
  logic [CH_W+1:0]    ch_ext;
  logic [CH_W-1:0]    idx;
  logic               cnt_full;
  logic [7:0]         cnt_next;
  logic [31:0]        sub_val;
  logic [31:0]        acc_next;
  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_q;
  logic signed [19:0] sat;

  assign ch_ext   = {{CH_W{1'b0}}, cur.ch};
  assign idx      = ch_ext[CH_W-1:0];
  assign cnt_full = (cnt[idx] == CNT_MAX);
  assign cnt_next = cnt_full ? cnt[idx] : cnt[idx] + 8'd1;
  assign sub_val  = cnt_full ? {{12{last[idx][19]}}, last[idx]} : 32'd0;
  assign acc_next = acc[idx] + {{11{cur.addend[20]}}, cur.addend} - sub_val;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign div_start = (state == S_CALC) && !cur.err;
  assign res_push  = (state == S_OUT) && !res_full;

  always_comb begin
    if (div_q > SAT_HI) begin
      sat = 20'(SAT_HI);
    end else if (div_q < SAT_LO) begin
      sat = 20'(SAT_LO);
    end else begin
      sat = div_q[19:0];
    end
  end

  mcsaf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_next),
    .divisor  (cnt_next),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (!q_empty) state_next = S_CALC;
      S_CALC:  state_next = cur.err ? S_OUT : S_DIV;
      S_DIV:   if (div_done) state_next = S_OUT;
      S_OUT:   if (!res_full) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (state == S_CALC) begin
      res.ch    <= cur.ch;
      res.value <= '0;
      res.err   <= cur.err;
    end
    if ((state == S_DIV) && div_done) begin
      res.value <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        acc[i]  <= '0;
        cnt[i]  <= '0;
        last[i] <= '0;
      end
    end else if (state == S_CALC) begin
      if (cur.err) begin
        acc[idx]  <= '0;
        cnt[idx]  <= '0;
        last[idx] <= '0;
      end else begin
        acc[idx] <= acc_next;
        cnt[idx] <= cnt_next;
      end
    end else if ((state == S_DIV) && div_done) begin
      last[idx] <= sat;
    end
  end

  `ASSERT_IMPLIES(a_cnt_bound, clk, rst, state == S_CALC, cnt[idx] <= CNT_MAX)
  `ASSERT_NEXT(a_div_to_out, clk, rst, (state == S_DIV) && div_done, state == S_OUT)
  `ASSERT_IMPLIES(a_err_zero, clk, rst, res_push && res.err, res.value == '0)
  `ASSERT_NEXT(a_start_wait, clk, rst, div_start, (state == S_DIV) && !div_done)

endmodule

// File: rtl/core/multichannel_sensor_average_filter_core.sv
// top level of the multichannel sensor running-average filter core
//
// input channel: a queue interface; a word (channel, sample) is taken at a
// rising edge with push high and full low. words of disabled or out-of-range
// channels are dropped at the door and produce no result.
// result channel: a queue interface; while empty is low the oldest result
// (out_channel, filtered_value, fault_flag) is on the ports and leaves on an
// edge with pop high.
// configuration: cfg_valid/cfg_ready write channel, always ready; index 0 is
// the channel enable mask, indexes 1 to 3 the per-channel offsets.
// path: a good sample accepted at an edge passes through pick-up, state
// update, 32 divider steps (one quotient bit each), quotient capture and
// queueing; a fault sample skips the divider. the back end handles one word
// at a time and takes no new word until its result is queued; the front
// queue holds 4 words and the result queue 2, so the sender and the receiver
// stall independently.
// reset: synchronous; queues empty, all channel state zero, mask all ones,
// offsets zero. a stalled receiver fills the result queue, then the back end
// holds its result, then the front queue fills and full rises.
module multichannel_sensor_average_filter_core
  import mcsaf_pkg::*;
#(
  parameter int CHANNELS  = 3,
  parameter int MAX_COUNT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         channel,
  input  logic signed [15:0] sample,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         out_channel,
  output logic signed [19:0] filtered_value,
  output logic               fault_flag,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [17:0]        cfg_data
);

  // classified word from the front end
  logic    keep;
  item_t   fr_item;
  // front-to-back queue
  item_t   q_item;
  logic    q_empty;
  logic    q_pop;
  // result queue
  logic    res_push;
  logic    res_full;
  result_t res_in;
  result_t res_out;

  mcsaf_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .channel   (channel),
    .sample    (sample),
    .accept    (push && !full),
    .keep      (keep),
    .item      (fr_item)
  );

  // dropped words never enter the queue
  mcsaf_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .push  (keep),
    .din   (fr_item),
    .full  (full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  mcsaf_back #(
    .CHANNELS  (CHANNELS),
    .MAX_COUNT (MAX_COUNT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // output queue parts the back end from the receiver
  mcsaf_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign out_channel    = res_out.ch;
  assign filtered_value = res_out.value;
  assign fault_flag     = res_out.err;

endmodule
